>>> src/fmf_pkg.sv
package fmf_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_TEXT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_LEN  = 1'b1;

    localparam logic [63:0] BEGIN_TEXT_RESET = 64'd14124550486247750;
    localparam logic [3:0]  BEGIN_LEN_RESET  = 4'd7;
    localparam logic [3:0]  BEGIN_LEN_MAX    = 4'd8;

    localparam logic [7:0] CHAR_SOH   = 8'h01;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_EIGHT = 8'h38;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       body_last;
    } item_t;

endpackage

>>> src/fmf_if.sv
interface fmf_cmd_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;
    logic       body_last;

    modport source (output valid, output func, output data_byte, output body_last,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input body_last,
                    output ready);
endinterface

interface fmf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       overflow;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    output overflow, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    input overflow, output ready);
endinterface

>>> src/fix_message_framer.sv
// tag-value message framer with trailing checksum
//
// cmd channel: one item per push (func 0, body byte, body_last) or pull (func 1).
// res channel: one item per pull, none per push. a pull while the body is still
// loading returns out_valid 0; otherwise the next byte of the framed message:
// 8=<begin>SOH 9=<length>SOH <body> 10=<checksum>SOH, out_last on the final SOH.
// cfg port: cfg_we with cfg_index 0 writes the begin string, index 1 its length.
//
// a pull item passes the item, then the result register. throughput: one item per
// cycle on cmd, push or pull, unless a pull waits on a stalled res; the item and
// result registers and the body buffer read port each take one item per cycle.
// the buffer read is registered and prefetched from the index the next pull needs.
//
// reset clears the counters, the message state and the overflow flag and loads
// the default begin string; the body buffer needs no clearing.
// when res stalls, the waiting result and the pull item behind it hold and cmd
// drops ready; pushes still drain since they produce no result.
module fix_message_framer #(
    parameter int BODY_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    fmf_cmd_if.sink                            cmd,
    fmf_res_if.source                          res,
    input  logic                               cfg_we,
    input  logic [fmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    function automatic int dec_width(input int v);
        int n;
        int p;
        n = 1;
        p = 10;
        for (int k = 0; k < 8; k++)
        begin
            if (p <= v)
            begin
                n = n + 1;
                p = p * 10;
            end
        end
        return n;
    endfunction

    localparam int CW = $clog2(BODY_DEPTH + 1);
    localparam int AW = $clog2(BODY_DEPTH);
    localparam int ND = dec_width(BODY_DEPTH);

    localparam logic [3:0] PH_LOAD  = 4'd0;
    localparam logic [3:0] PH_TAG8  = 4'd1;
    localparam logic [3:0] PH_BEGIN = 4'd2;
    localparam logic [3:0] PH_SOH1  = 4'd3;
    localparam logic [3:0] PH_TAG9  = 4'd4;
    localparam logic [3:0] PH_LEN   = 4'd5;
    localparam logic [3:0] PH_SOH2  = 4'd6;
    localparam logic [3:0] PH_BODY  = 4'd7;
    localparam logic [3:0] PH_TAG10 = 4'd8;
    localparam logic [3:0] PH_CSUM  = 4'd9;
    localparam logic [3:0] PH_SOH3  = 4'd10;

    function automatic logic phase_done(input logic [3:0] ph, input logic [CW-1:0] ix,
                                        input logic [3:0] bl, input logic [CW-1:0] nd,
                                        input logic [CW-1:0] cnt);
        logic d;
        d = 1'b0;
        unique case (ph)
            PH_TAG8, PH_TAG9: d = (ix >= CW'(2));
            PH_BEGIN:         d = (ix >= CW'(bl));
            PH_SOH1, PH_SOH2, PH_SOH3: d = (ix >= CW'(1));
            PH_LEN:           d = (ix >= nd);
            PH_BODY:          d = (ix >= cnt);
            PH_TAG10, PH_CSUM: d = (ix >= CW'(3));
            default:          d = 1'b0;
        endcase
        return d;
    endfunction

    logic [7:0] body_mem [BODY_DEPTH];
    logic [7:0] mem_q_reg;

    logic [63:0]       begin_text_reg;
    logic [3:0]        begin_len_reg;

    logic              in_valid_reg;
    fmf_pkg::item_t    in_item_reg;

    logic [3:0]        phase_reg, phase_next;
    logic [CW-1:0]     index_reg, index_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ND-1:0][3:0] bcd_reg, bcd_next;
    logic [7:0]        sum_reg, sum_next;
    logic              ovf_reg, ovf_next;

    logic              res_valid_reg, res_valid_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_fvalid_reg, res_fvalid_next;
    logic              res_last_reg, res_last_next;
    logic              res_ovf_reg, res_ovf_next;

    logic              res_free;
    logic              proc;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;

    logic [3:0]        blen;
    logic [CW-1:0]     ndig;
    logic              done0, done1;
    logic [3:0]        ph1, phe;
    logic [CW-1:0]     ix1, ixe;
    logic [CW-1:0]     len_pos;
    logic [3:0]        len_digit;
    logic [1:0]        cs_h;
    logic [6:0]        cs_r;
    logic [14:0]       cs_prod;
    logic [3:0]        cs_t;
    logic [3:0]        cs_o;
    logic [7:0]        emit_byte;
    logic              carry;

    assign res_free  = !res_valid_reg || res.ready;
    assign proc      = in_valid_reg && ((in_item_reg.func == fmf_pkg::FUNC_PUSH) || res_free);
    assign cmd.ready = !in_valid_reg || proc;

    assign res.valid     = res_valid_reg;
    assign res.out_byte  = res_byte_reg;
    assign res.out_valid = res_fvalid_reg;
    assign res.out_last  = res_last_reg;
    assign res.overflow  = res_ovf_reg;

    assign blen = (begin_len_reg > fmf_pkg::BEGIN_LEN_MAX) ? fmf_pkg::BEGIN_LEN_MAX
                                                           : begin_len_reg;

    // significant decimal digits of the body length
    always_comb
    begin
        ndig = CW'(1);
        for (int k = 1; k < ND; k++)
        begin
            if (bcd_reg[k] != 4'd0)
            begin
                ndig = CW'(k + 1);
            end
        end
    end

    // skip phases that have nothing left to send, at most two in a row
    always_comb
    begin
        done0 = phase_done(phase_reg, index_reg, blen, ndig, count_reg);
        ph1   = done0 ? phase_reg + 4'd1 : phase_reg;
        ix1   = done0 ? '0 : index_reg;
        done1 = phase_done(ph1, ix1, blen, ndig, count_reg);
        phe   = done1 ? ph1 + 4'd1 : ph1;
        ixe   = done1 ? '0 : ix1;
    end

    always_comb
    begin
        len_pos   = ndig - CW'(1) - ixe;
        len_digit = 4'd0;
        for (int k = 0; k < ND; k++)
        begin
            if (len_pos == CW'(k))
            begin
                len_digit = bcd_reg[k];
            end
        end
    end

    // checksum digits
    always_comb
    begin
        if (sum_reg >= 8'd200)
        begin
            cs_h = 2'd2;
            cs_r = 7'(sum_reg - 8'd200);
        end
        else if (sum_reg >= 8'd100)
        begin
            cs_h = 2'd1;
            cs_r = 7'(sum_reg - 8'd100);
        end
        else
        begin
            cs_h = 2'd0;
            cs_r = sum_reg[6:0];
        end
        cs_prod = 15'(cs_r) * 15'd205;
        cs_t    = cs_prod[14:11];
        cs_o    = 4'(cs_r - 7'(cs_t) * 7'd10);
    end

    always_comb
    begin
        emit_byte = fmf_pkg::CHAR_SOH;
        unique case (phe)
            PH_TAG8:  emit_byte = (ixe == '0) ? fmf_pkg::CHAR_EIGHT : fmf_pkg::CHAR_EQ;
            PH_BEGIN: emit_byte = begin_text_reg[{ixe[2:0], 3'b000} +: 8];
            PH_TAG9:  emit_byte = (ixe == '0) ? fmf_pkg::CHAR_NINE : fmf_pkg::CHAR_EQ;
            PH_LEN:   emit_byte = fmf_pkg::CHAR_ZERO + 8'(len_digit);
            PH_BODY:  emit_byte = mem_q_reg;
            PH_TAG10:
            begin
                if (ixe == '0)
                begin
                    emit_byte = fmf_pkg::CHAR_ONE;
                end
                else if (ixe == CW'(1))
                begin
                    emit_byte = fmf_pkg::CHAR_ZERO;
                end
                else
                begin
                    emit_byte = fmf_pkg::CHAR_EQ;
                end
            end
            PH_CSUM:
            begin
                if (ixe == '0)
                begin
                    emit_byte = fmf_pkg::CHAR_ZERO + 8'(cs_h);
                end
                else if (ixe == CW'(1))
                begin
                    emit_byte = fmf_pkg::CHAR_ZERO + 8'(cs_t);
                end
                else
                begin
                    emit_byte = fmf_pkg::CHAR_ZERO + 8'(cs_o);
                end
            end
            default:  emit_byte = fmf_pkg::CHAR_SOH;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        index_next      = index_reg;
        count_next      = count_reg;
        bcd_next        = bcd_reg;
        sum_next        = sum_reg;
        ovf_next        = ovf_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_byte_next   = res_byte_reg;
        res_fvalid_next = res_fvalid_reg;
        res_last_next   = res_last_reg;
        res_ovf_next    = res_ovf_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        carry           = 1'b1;

        if (proc)
        begin
            if (in_item_reg.func == fmf_pkg::FUNC_PUSH)
            begin
                if (phase_reg == PH_LOAD)
                begin
                    if (count_reg < CW'(BODY_DEPTH))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        for (int k = 0; k < ND; k++)
                        begin
                            if (carry)
                            begin
                                if (bcd_reg[k] == 4'd9)
                                begin
                                    bcd_next[k] = 4'd0;
                                end
                                else
                                begin
                                    bcd_next[k] = bcd_reg[k] + 4'd1;
                                    carry       = 1'b0;
                                end
                            end
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_item_reg.body_last)
                    begin
                        phase_next = PH_TAG8;
                        index_next = '0;
                        sum_next   = '0;
                    end
                end
            end
            else
            begin
                res_valid_next = 1'b1;
                res_ovf_next   = ovf_reg;
                if (phase_reg == PH_LOAD)
                begin
                    res_byte_next   = 8'd0;
                    res_fvalid_next = 1'b0;
                    res_last_next   = 1'b0;
                end
                else
                begin
                    res_byte_next   = emit_byte;
                    res_fvalid_next = 1'b1;
                    res_last_next   = (phe == PH_SOH3);
                    if (phe < PH_TAG10)
                    begin
                        sum_next = sum_reg + emit_byte;
                    end
                    if (phe == PH_SOH3)
                    begin
                        phase_next = PH_LOAD;
                        index_next = '0;
                        count_next = '0;
                        bcd_next   = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        phase_next = phe;
                        index_next = ixe + CW'(1);
                    end
                end
            end
        end
    end

    // prefetch the body byte the next pull will need
    assign mem_raddr = (phase_next == PH_BODY) ? index_next[AW-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            body_mem[mem_waddr] <= in_item_reg.data_byte;
        end
        mem_q_reg <= body_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready)
        begin
            in_item_reg.func      <= cmd.func;
            in_item_reg.data_byte <= cmd.data_byte;
            in_item_reg.body_last <= cmd.body_last;
        end
        res_byte_reg   <= res_byte_next;
        res_fvalid_reg <= res_fvalid_next;
        res_last_reg   <= res_last_next;
        res_ovf_reg    <= res_ovf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            phase_reg      <= PH_LOAD;
            index_reg      <= '0;
            count_reg      <= '0;
            bcd_reg        <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            begin_text_reg <= fmf_pkg::BEGIN_TEXT_RESET;
            begin_len_reg  <= fmf_pkg::BEGIN_LEN_RESET;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            res_valid_reg <= res_valid_next;
            phase_reg     <= phase_next;
            index_reg     <= index_next;
            count_reg     <= count_next;
            bcd_reg       <= bcd_next;
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fmf_pkg::REG_BEGIN_TEXT: begin_text_reg <= cfg_data;
                    fmf_pkg::REG_BEGIN_LEN:  begin_len_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BODY_DEPTH))
        else $error("body count beyond buffer depth");

    a_body_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (index_reg <= count_reg))
        else $error("body index past body length");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_trailer_end: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_item_reg.func == fmf_pkg::FUNC_PULL && phase_reg != PH_LOAD
         && phe == PH_SOH3)
        |=> (phase_reg == PH_LOAD && count_reg == '0 && res_last_reg && res_valid_reg))
        else $error("closing byte did not return to loading");

endmodule
